// ===== rtl/tvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tag/value store with bump-allocated pools.
// Used by tvs_pool_ram and tag_value_store_bump_pool_unit; no dependencies.

package tvs_pkg;

    localparam int TAG_COUNT_DEF     = 64;
    localparam int POOL_BYTES_DEF    = 4096;
    localparam int MAX_VALUE_LEN_DEF = 64;
    localparam int RECORD_COUNT_DEF  = 4;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        record;
        logic [5:0]        tag;
        logic [LEN_W-1:0]  value_len;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  max_len;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  copied_len;
        logic              last_result;
    } out_item_t;

    function automatic out_item_t mk_result(input logic status, input logic [BYTE_W-1:0] b,
                                            input logic bv, input logic [LEN_W-1:0] len,
                                            input logic last);
        out_item_t r;
        r.status      = status;
        r.out_byte    = b;
        r.byte_valid  = bv;
        r.copied_len  = len;
        r.last_result = last;
        return r;
    endfunction

endpackage

// ===== rtl/tvs_pool_ram.sv =====
`timescale 1ns / 1ps
// Byte pool memory: one write port, one read port, registered read data.
// Depends on tvs_pkg for the byte width.

module tvs_pool_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tvs_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tvs_pkg::BYTE_W-1:0] rdata
);

    logic [tvs_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [tvs_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tag_value_store_bump_pool_unit.sv =====
`timescale 1ns / 1ps
// Top level of the tag/value store: entry table, bump pointers, update runs and get streaming.
// Depends on tvs_pkg and tvs_pool_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  in      | in_valid / in_ready  | in_item  (tvs_pkg::in_item_t)
//  out     | out_valid / out_ready| out_item (tvs_pkg::out_item_t)
//
// Delete, later bytes of an update run and unused codes are handled in ST_IDLE.
// The first item of an update run and an empty get also pass through ST_LOOKUP (entry table read).
// A get returning n bytes passes through ST_LOOKUP and ST_GET: one pool read per returned byte.
// Reset clears valid bits, bump pointers and run state at once; no clearing pass.
// A stalled result holds in the output register; in_ready drops only until it is taken.

module tag_value_store_bump_pool_unit #(
    parameter int TAG_COUNT     = tvs_pkg::TAG_COUNT_DEF,
    parameter int POOL_BYTES    = tvs_pkg::POOL_BYTES_DEF,
    parameter int MAX_VALUE_LEN = tvs_pkg::MAX_VALUE_LEN_DEF,
    parameter int RECORD_COUNT  = tvs_pkg::RECORD_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tvs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tvs_pkg::out_item_t out_item
);

    localparam int LEN_W  = tvs_pkg::LEN_W;
    localparam int SLOTS  = RECORD_COUNT * TAG_COUNT;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int OFF_W  = $clog2(POOL_BYTES);
    localparam int BP_W   = $clog2(POOL_BYTES + 1);
    localparam int PA_W   = $clog2(RECORD_COUNT * POOL_BYTES);
    localparam int REC_W  = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
    localparam int ENT_W  = OFF_W + LEN_W;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_GET} state_t;

    state_t             state_reg, state_next;
    tvs_pkg::in_item_t  req_reg, req_next;

    logic               run_active_reg, run_active_next;
    logic               run_dropped_reg, run_dropped_next;
    logic [PA_W-1:0]    run_addr_reg, run_addr_next;
    logic [LEN_W-1:0]   run_left_reg, run_left_next;
    logic [LEN_W-1:0]   run_len_reg, run_len_next;

    logic [PA_W-1:0]    get_addr_reg, get_addr_next;
    logic [LEN_W-1:0]   get_idx_reg, get_idx_next;
    logic [LEN_W-1:0]   get_n_reg, get_n_next;

    logic               out_valid_reg, out_valid_next;
    tvs_pkg::out_item_t out_item_reg, out_item_next;

    logic               entry_valid_reg [SLOTS];
    logic [BP_W-1:0]    bump_reg [RECORD_COUNT];

    logic [ENT_W-1:0]   entry_mem [SLOTS];
    logic [ENT_W-1:0]   entry_rdata_reg;
    logic               ent_re, ent_we;
    logic [SLOT_W-1:0]  ent_raddr;
    logic [ENT_W-1:0]   ent_wdata;

    logic               valid_set, valid_clr;
    logic [SLOT_W-1:0]  valid_idx;
    logic               bump_we;
    logic [BP_W-1:0]    bump_wdata;

    logic               pool_we, pool_re;
    logic [PA_W-1:0]    pool_waddr, pool_raddr;
    logic [tvs_pkg::BYTE_W-1:0] pool_wdata, pool_rdata;

    logic               in_fire, in_ok;
    logic [SLOT_W-1:0]  in_slot;
    logic               req_ok, hit;
    logic [SLOT_W-1:0]  req_slot;
    logic [REC_W-1:0]   rec_idx;
    logic [PA_W-1:0]    rec_base;
    logic [OFF_W-1:0]   old_off, new_off;
    logic [LEN_W-1:0]   old_len, new_len, get_n;
    logic [BP_W-1:0]    bump_cur;
    logic               fits, in_place, upd_drop;
    logic [PA_W-1:0]    upd_base, get_base;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign in_ok   = (32'(in_item.record) < RECORD_COUNT) && (32'(in_item.tag) < TAG_COUNT);
    assign in_slot = SLOT_W'(32'(in_item.record) * TAG_COUNT + 32'(in_item.tag));

    // Lookup-side decode, from the held request and the entry table read data
    assign req_ok   = (32'(req_reg.record) < RECORD_COUNT) && (32'(req_reg.tag) < TAG_COUNT);
    assign req_slot = SLOT_W'(32'(req_reg.record) * TAG_COUNT + 32'(req_reg.tag));
    assign rec_idx  = REC_W'(req_reg.record);
    assign rec_base = PA_W'(32'(req_reg.record) * POOL_BYTES);
    assign hit      = req_ok && entry_valid_reg[req_slot];
    assign old_off  = entry_rdata_reg[ENT_W-1:LEN_W];
    assign old_len  = entry_rdata_reg[LEN_W-1:0];
    assign new_len  = (req_reg.value_len > LEN_W'(MAX_VALUE_LEN)) ? LEN_W'(MAX_VALUE_LEN)
                                                                 : req_reg.value_len;
    assign bump_cur = bump_reg[rec_idx];
    assign fits     = ((BP_W+1)'(bump_cur) + (BP_W+1)'(new_len)) <= (BP_W+1)'(POOL_BYTES);
    assign in_place = hit && (old_len >= new_len);
    assign upd_drop = !req_ok || (!in_place && !fits);
    assign new_off  = in_place ? old_off : ((new_len != '0) ? OFF_W'(bump_cur) : '0);
    assign upd_base = rec_base + PA_W'(new_off);
    assign get_base = rec_base + PA_W'(old_off);
    assign get_n    = (req_reg.max_len < old_len) ? req_reg.max_len : old_len;

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        run_active_next  = run_active_reg;
        run_dropped_next = run_dropped_reg;
        run_addr_next    = run_addr_reg;
        run_left_next    = run_left_reg;
        run_len_next     = run_len_reg;
        get_addr_next    = get_addr_reg;
        get_idx_next     = get_idx_reg;
        get_n_next       = get_n_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_item_next    = out_item_reg;

        ent_re     = 1'b0;
        ent_raddr  = in_slot;
        ent_we     = 1'b0;
        ent_wdata  = {new_off, new_len};
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        valid_idx  = req_slot;
        bump_we    = 1'b0;
        bump_wdata = bump_cur + BP_W'(new_len);
        pool_we    = 1'b0;
        pool_waddr = run_addr_reg;
        pool_wdata = in_item.data_byte;
        pool_re    = 1'b0;
        pool_raddr = get_addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next = in_item;
                    case (in_item.req_type)
                        tvs_pkg::REQ_UPDATE:
                        begin
                            if (!run_active_reg)
                            begin
                                ent_re     = 1'b1;
                                state_next = ST_LOOKUP;
                            end
                            else
                            begin
                                if (!run_dropped_reg && run_left_reg != '0)
                                begin
                                    pool_we       = 1'b1;
                                    run_addr_next = run_addr_reg + 1'b1;
                                    run_left_next = run_left_reg - 1'b1;
                                end
                                if (in_item.last_byte)
                                begin
                                    run_active_next = 1'b0;
                                    out_valid_next  = 1'b1;
                                    out_item_next   = tvs_pkg::mk_result(
                                        run_dropped_reg ? tvs_pkg::STATUS_DROPPED
                                                        : tvs_pkg::STATUS_OK,
                                        '0, 1'b0, run_dropped_reg ? '0 : run_len_reg, 1'b1);
                                end
                            end
                        end
                        tvs_pkg::REQ_GET:
                        begin
                            ent_re     = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        tvs_pkg::REQ_DELETE:
                        begin
                            valid_clr      = in_ok;
                            valid_idx      = in_slot;
                            out_valid_next = 1'b1;
                            out_item_next  = tvs_pkg::mk_result(tvs_pkg::STATUS_OK, '0, 1'b0,
                                                                '0, 1'b1);
                        end
                        default:
                        begin
                            // unused code: take the item, give nothing
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                if (req_reg.req_type == tvs_pkg::REQ_UPDATE)
                begin
                    run_dropped_next = upd_drop;
                    run_len_next     = upd_drop ? '0 : new_len;
                    run_addr_next    = upd_base;
                    run_left_next    = upd_drop ? '0 : new_len;
                    if (!upd_drop)
                    begin
                        ent_we    = 1'b1;
                        valid_set = 1'b1;
                        bump_we   = !in_place;
                        // first byte of the run goes straight in
                        if (new_len != '0)
                        begin
                            pool_we       = 1'b1;
                            pool_waddr    = upd_base;
                            pool_wdata    = req_reg.data_byte;
                            run_addr_next = upd_base + 1'b1;
                            run_left_next = new_len - 1'b1;
                        end
                    end
                    run_active_next = !req_reg.last_byte;
                    if (req_reg.last_byte)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = tvs_pkg::mk_result(
                            upd_drop ? tvs_pkg::STATUS_DROPPED : tvs_pkg::STATUS_OK,
                            '0, 1'b0, upd_drop ? '0 : new_len, 1'b1);
                    end
                end
                else if (!hit || get_n == '0)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = tvs_pkg::mk_result(tvs_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    pool_re       = 1'b1;
                    pool_raddr    = get_base;
                    get_addr_next = get_base;
                    get_idx_next  = '0;
                    get_n_next    = get_n;
                    state_next    = ST_GET;
                end
            end

            ST_GET:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = tvs_pkg::mk_result(tvs_pkg::STATUS_OK, pool_rdata, 1'b1,
                                                        get_n_reg,
                                                        (get_idx_reg + 1'b1) == get_n_reg);
                    if ((get_idx_reg + 1'b1) == get_n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next pool byte
                        get_idx_next  = get_idx_reg + 1'b1;
                        get_addr_next = get_addr_reg + 1'b1;
                        pool_re       = 1'b1;
                        pool_raddr    = get_addr_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            run_active_reg  <= 1'b0;
            run_dropped_reg <= 1'b0;
            run_addr_reg    <= '0;
            run_left_reg    <= '0;
            run_len_reg     <= '0;
            get_idx_reg     <= '0;
            get_n_reg       <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
            for (int r = 0; r < RECORD_COUNT; r++)
            begin
                bump_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            run_active_reg  <= run_active_next;
            run_dropped_reg <= run_dropped_next;
            run_addr_reg    <= run_addr_next;
            run_left_reg    <= run_left_next;
            run_len_reg     <= run_len_next;
            get_idx_reg     <= get_idx_next;
            get_n_reg       <= get_n_next;
            out_valid_reg   <= out_valid_next;
            if (valid_set)
            begin
                entry_valid_reg[valid_idx] <= 1'b1;
            end
            else if (valid_clr)
            begin
                entry_valid_reg[valid_idx] <= 1'b0;
            end
            if (bump_we)
            begin
                bump_reg[rec_idx] <= bump_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        get_addr_reg <= get_addr_next;
        out_item_reg <= out_item_next;
    end

    // Entry table: offset and length per slot, registered read issued in ST_IDLE and used in ST_LOOKUP
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[req_slot] <= ent_wdata;
        end
        if (ent_re)
        begin
            entry_rdata_reg <= entry_mem[ent_raddr];
        end
    end

    tvs_pool_ram #(
        .DEPTH  (RECORD_COUNT * POOL_BYTES),
        .ADDR_W (PA_W)
    ) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    a_byte_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.byte_valid |-> out_item_reg.copied_len != '0)
        else $error("value byte with zero copied length");

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status |->
            out_item_reg.copied_len == '0 && out_item_reg.last_result && !out_item_reg.byte_valid)
        else $error("dropped update result carries data");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_left_reg <= run_len_reg)
        else $error("run byte count exceeds stored length");

    a_entry_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP && req_reg.req_type == tvs_pkg::REQ_UPDATE && !upd_drop
            |=> entry_valid_reg[$past(req_slot)])
        else $error("accepted update left its entry invalid");

    a_get_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GET |-> get_idx_reg < get_n_reg)
        else $error("get index ran past its byte count");

endmodule

// ===== sim/tag_value_store_bump_pool_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tag_value_store_bump_pool_unit: directed and random requests
// checked against an in-bench model of the tag tables, byte pools and update runs.
// Depends on tvs_pkg and the RTL top level.

module tag_value_store_bump_pool_unit_tb;

    localparam int RECS        = tvs_pkg::RECORD_COUNT_DEF;
    localparam int TAGS        = tvs_pkg::TAG_COUNT_DEF;
    localparam int POOL        = tvs_pkg::POOL_BYTES_DEF;
    localparam int VAL_MAX     = tvs_pkg::MAX_VALUE_LEN_DEF;
    localparam int SLOTS       = RECS * TAGS;
    localparam int RANDOM_ITEMS = 60;
    localparam int TAIL_CYCLES = 200;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        tvs_pkg::in_item_t item;
        int                nres;
        bit                hold;
    } request_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    tvs_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    tvs_pkg::out_item_t out_item;

    tag_value_store_bump_pool_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Model of the store
    logic        tag_valid  [SLOTS];
    logic [11:0] tag_offset [SLOTS];
    logic [6:0]  tag_length [SLOTS];
    logic [7:0]  pool_data  [RECS*POOL];
    bit          pool_known [RECS*POOL];
    logic [12:0] bump_at    [RECS];
    bit          run_open;
    bit          run_drop;
    int          run_addr;
    int          run_todo;
    logic [6:0]  run_len;

    request_t           request_q[$];
    tvs_pkg::out_item_t pending_results[$];   // predicted, item not yet accepted
    tvs_pkg::out_item_t owed_results[$];      // item accepted, result still to come

    int counted      = 0;
    int total_items  = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;

    int                 cur_nres   = 0;
    int                 send_gap   = 0;
    bit                 send_quiet = 0;
    int                 take_gap   = 0;
    bit                 take_quiet = 0;
    request_t           nxt;
    tvs_pkg::out_item_t want;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void note_result(logic st, logic [7:0] b, logic bv, logic [6:0] len,
                                        logic last);
        tvs_pkg::out_item_t r;
        r.status      = st;
        r.out_byte    = b;
        r.byte_valid  = bv;
        r.copied_len  = len;
        r.last_result = last;
        pending_results.push_back(r);
    endfunction

    // Advance the model by one item; return how many results it causes.
    function automatic int answer_request(tvs_pkg::in_item_t it);
        int slot;
        int base;
        int n;
        int vl;
        int i;
        bit ok;
        ok   = int'(it.record) < RECS && int'(it.tag) < TAGS;
        slot = ok ? int'(it.record) * TAGS + int'(it.tag) : 0;
        case (it.req_type)
            tvs_pkg::REQ_UPDATE:
            begin
                if (!run_open)
                begin
                    vl       = int'(it.value_len) > VAL_MAX ? VAL_MAX : int'(it.value_len);
                    run_open = 1;
                    run_drop = 0;
                    run_todo = 0;
                    run_len  = '0;
                    run_addr = 0;
                    if (!ok)
                        run_drop = 1;
                    else if (tag_valid[slot] && int'(tag_length[slot]) >= vl)
                        run_addr = int'(it.record) * POOL + int'(tag_offset[slot]);
                    else if (int'(bump_at[it.record]) + vl > POOL)
                        run_drop = 1;
                    else
                    begin
                        tag_offset[slot]   = (vl != 0) ? bump_at[it.record][11:0] : 12'd0;
                        bump_at[it.record] = bump_at[it.record] + 13'(vl);
                        run_addr = int'(it.record) * POOL + int'(tag_offset[slot]);
                    end
                    if (!run_drop)
                    begin
                        tag_valid[slot]  = 1'b1;
                        tag_length[slot] = 7'(vl);
                        run_todo = vl;
                        run_len  = 7'(vl);
                    end
                end
                if (!run_drop && run_todo > 0)
                begin
                    pool_data[run_addr]  = it.data_byte;
                    pool_known[run_addr] = 1;
                    run_addr++;
                    run_todo--;
                end
                if (!it.last_byte)
                    return 0;
                run_open = 0;
                note_result(run_drop ? tvs_pkg::STATUS_DROPPED : tvs_pkg::STATUS_OK, 8'd0, 1'b0,
                            run_drop ? 7'd0 : run_len, 1'b1);
                return 1;
            end
            tvs_pkg::REQ_GET:
            begin
                if (!ok || !tag_valid[slot])
                    n = 0;
                else if (int'(it.max_len) < int'(tag_length[slot]))
                    n = int'(it.max_len);
                else
                    n = int'(tag_length[slot]);
                if (n == 0)
                begin
                    note_result(tvs_pkg::STATUS_OK, 8'd0, 1'b0, 7'd0, 1'b1);
                    return 1;
                end
                base = int'(it.record) * POOL + int'(tag_offset[slot]);
                for (i = 0; i < n; i++)
                    note_result(tvs_pkg::STATUS_OK, pool_data[base + i], 1'b1, 7'(n),
                                i == n - 1);
                return n;
            end
            tvs_pkg::REQ_DELETE:
            begin
                if (ok)
                begin
                    tag_valid[slot]  = 1'b0;
                    tag_length[slot] = 7'd0;
                end
                note_result(tvs_pkg::STATUS_OK, 8'd0, 1'b0, 7'd0, 1'b1);
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    // Trim a get so that it never reaches a pool byte that was never written.
    function automatic logic [6:0] readable_len(logic [1:0] rec, logic [5:0] tag,
                                                logic [6:0] span);
        int slot;
        int n;
        int base;
        int k;
        slot = int'(rec) * TAGS + int'(tag);
        if (!tag_valid[slot])
            return span;
        n    = span < tag_length[slot] ? int'(span) : int'(tag_length[slot]);
        base = int'(rec) * POOL + int'(tag_offset[slot]);
        for (k = 0; k < n; k++)
            if (!pool_known[base + k])
                return 7'(k);
        return span;
    endfunction

    function automatic tvs_pkg::in_item_t rand_item();
        return tvs_pkg::in_item_t'({$urandom, 1'($urandom)});
    endfunction

    function automatic int pick_tag();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, TAGS - 1) : $urandom_range(0, 7);
    endfunction

    function automatic int pick_span();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(VAL_MAX + 1, 127)
                                            : $urandom_range(0, VAL_MAX);
    endfunction

    task automatic send(tvs_pkg::in_item_t it, bit hold);
        request_t r;
        if (it.req_type == tvs_pkg::REQ_GET)
            it.max_len = readable_len(it.record, it.tag, it.max_len);
        r.item = it;
        r.hold = hold;
        r.nres = answer_request(it);
        request_q.push_back(r);
        if (it.req_type != REQ_UNUSED)
            counted++;
    endtask

    task automatic add_update(int rec, int tag, int vlen, int data, bit last);
        tvs_pkg::in_item_t it;
        it           = rand_item();
        it.req_type  = tvs_pkg::REQ_UPDATE;
        it.record    = 2'(rec);
        it.tag       = 6'(tag);
        it.value_len = 7'(vlen);
        it.data_byte = 8'(data);
        it.last_byte = last;
        send(it, 0);
    endtask

    task automatic add_query(logic [1:0] kind, int rec, int tag, int span, bit hold);
        tvs_pkg::in_item_t it;
        it          = rand_item();
        it.req_type = kind;
        it.record   = 2'(rec);
        it.tag      = 6'(tag);
        it.max_len  = 7'(span);
        send(it, hold);
    endtask

    task automatic check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // Stimulus, then end of run
    initial
    begin
        int s;
        int rec;
        int tag;
        int vlen;
        int span;
        int nbytes;
        int b;
        int pick;
        int room;
        int stop_at;
        bit exhausted;

        for (s = 0; s < SLOTS; s++)
        begin
            tag_valid[s]  = 1'b0;
            tag_offset[s] = '0;
            tag_length[s] = '0;
        end
        for (s = 0; s < RECS; s++)
            bump_at[s] = '0;
        run_open  = 0;
        run_drop  = 0;
        run_addr  = 0;
        run_todo  = 0;
        run_len   = '0;
        exhausted = 0;

        add_query(tvs_pkg::REQ_GET, 0, 0, VAL_MAX, 0);     // empty table
        add_update(0, 5, 3, 8'hA5, 0);
        add_update(0, 5, 3, 8'h00, 0);
        add_update(0, 5, 3, 8'hFF, 1);
        add_query(tvs_pkg::REQ_GET, 0, 5, VAL_MAX, 0);
        add_query(tvs_pkg::REQ_GET, 0, 5, 2, 0);           // clipped by max_len
        add_query(tvs_pkg::REQ_GET, 0, 5, 0, 0);           // zero copy
        add_update(0, 5, 2, 8'h3C, 0);                     // shorter: overwrite in place
        add_update(0, 5, 2, 8'hC3, 1);
        add_query(tvs_pkg::REQ_GET, 0, 5, 127, 0);
        add_update(1, 63, 127, 8'h81, 0);                  // long value, run cut short
        add_update(1, 63, 127, 8'h7E, 1);
        add_query(tvs_pkg::REQ_GET, 1, 63, VAL_MAX, 0);
        add_update(2, 0, 0, 8'hFF, 1);                     // zero length
        add_query(tvs_pkg::REQ_GET, 2, 0, VAL_MAX, 0);
        add_update(0, 9, 1, 8'h00, 0);                     // bytes past the length
        add_update(0, 9, 1, 8'hFF, 0);
        add_update(0, 9, 1, 8'h5A, 1);
        add_query(REQ_UNUSED, 3, 63, VAL_MAX, 0);
        add_update(3, 63, 4, 8'h11, 0);                    // get and delete inside a run
        add_query(tvs_pkg::REQ_GET, 0, 9, VAL_MAX, 0);
        add_query(tvs_pkg::REQ_DELETE, 0, 5, 0, 0);
        add_update(3, 63, 4, 8'h22, 0);
        add_update(3, 63, 4, 8'h33, 0);
        add_update(3, 63, 4, 8'h44, 1);
        add_query(tvs_pkg::REQ_GET, 3, 63, 127, 1);        // hold until drained
        add_query(tvs_pkg::REQ_GET, 0, 5, VAL_MAX, 0);
        add_query(tvs_pkg::REQ_DELETE, 1, 10, 0, 0);

        stop_at = counted + RANDOM_ITEMS;
        while (counted < stop_at)
        begin
            if (!exhausted && counted >= stop_at - RANDOM_ITEMS / 2)
            begin
                // Fill one pool to the last byte, then push past its end
                exhausted = 1;
                rec = $urandom_range(0, RECS - 1);
                tag = 0;
                while (int'(bump_at[rec]) < POOL)
                begin
                    room = POOL - int'(bump_at[rec]);
                    vlen = room > VAL_MAX ? VAL_MAX : room;
                    if (tag_valid[rec * TAGS + tag])
                        add_query(tvs_pkg::REQ_DELETE, rec, tag, 0, 0);
                    add_update(rec, tag, vlen, $urandom_range(0, 255), 1);
                    tag = (tag + 1) % TAGS;
                end
                if (tag_valid[rec * TAGS + tag])
                    add_query(tvs_pkg::REQ_DELETE, rec, tag, 0, 0);
                add_update(rec, tag, 0, 8'hFF, 1);
                tag = (tag + 1) % TAGS;
                if (tag_valid[rec * TAGS + tag])
                    add_query(tvs_pkg::REQ_DELETE, rec, tag, 0, 0);
                add_update(rec, tag, 5, $urandom_range(0, 255), 0);
                add_update(rec, tag, 5, $urandom_range(0, 255), 0);
                add_update(rec, tag, 5, $urandom_range(0, 255), 1);
                add_query(tvs_pkg::REQ_GET, rec, tag, VAL_MAX, 0);
            end
            pick = $urandom_range(0, 19);
            if (pick < 11)
            begin
                rec = $urandom_range(0, RECS - 1);
                tag = pick_tag();
                case ($urandom_range(0, 19))
                    0, 1:    vlen = 0;
                    2:       vlen = $urandom_range(9, VAL_MAX);
                    3:       vlen = $urandom_range(VAL_MAX + 1, 127);
                    default: vlen = $urandom_range(1, 8);
                endcase
                span = vlen > VAL_MAX ? VAL_MAX : vlen;
                case ($urandom_range(0, 9))
                    0:       nbytes = $urandom_range(1, span > 1 ? span : 1);
                    1:       nbytes = span + $urandom_range(1, 3);
                    default: nbytes = span > 0 ? span : 1;
                endcase
                if (vlen > VAL_MAX)
                    nbytes = $urandom_range(1, 4);
                for (b = 0; b < nbytes; b++)
                begin
                    // Only the first item's record, tag and length count
                    if (b == 0)
                        add_update(rec, tag, vlen, $urandom_range(0, 255), nbytes == 1);
                    else
                        add_update($urandom_range(0, RECS - 1), $urandom_range(0, TAGS - 1),
                                   $urandom_range(0, 127), $urandom_range(0, 255),
                                   b == nbytes - 1);
                    if (b != nbytes - 1 && $urandom_range(0, 9) == 0)
                        add_query(($urandom_range(0, 2) == 0) ? tvs_pkg::REQ_DELETE
                                                              : tvs_pkg::REQ_GET,
                                  $urandom_range(0, RECS - 1), pick_tag(), pick_span(), 0);
                end
            end
            else if (pick < 16)
                add_query(tvs_pkg::REQ_GET, $urandom_range(0, RECS - 1), pick_tag(), pick_span(),
                          $urandom_range(0, 31) == 0);
            else if (pick < 19)
                add_query(tvs_pkg::REQ_DELETE, $urandom_range(0, RECS - 1), pick_tag(),
                          pick_span(), 0);
            else
                add_query(REQ_UNUSED, $urandom_range(0, RECS - 1), pick_tag(), pick_span(), 0);
        end
        total_items = request_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != total_items)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && owed_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                repeat (cur_nres) owed_results.push_back(pending_results.pop_front());
                accepted_cnt++;
            end
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (request_q.size() != 0 && (!request_q[0].hold || owed_results.size() == 0))
            begin
                nxt = request_q.pop_front();
                in_item  <= nxt.item;
                in_valid <= 1'b1;
                cur_nres = nxt.nres;
                if ($urandom_range(0, 15) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t ns: result with nothing owed, got %h", $time, out_item);
                fail_cnt++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("status", 8'(want.status), 8'(out_item.status));
                check_field("out_byte", want.out_byte, out_item.out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(out_item.byte_valid));
                check_field("copied_len", 8'(want.copied_len), 8'(out_item.copied_len));
                check_field("last_result", 8'(want.last_result), 8'(out_item.last_result));
            end
            if ($urandom_range(0, 15) == 0)
                take_quiet = !take_quiet;
            take_gap = take_quiet ? 0 : $urandom_range(0, 13);
            out_ready <= (take_gap == 0);
        end
        else if (take_gap != 0)
        begin
            take_gap--;
            out_ready <= (take_gap == 0);
        end
        else
            out_ready <= 1'b1;
    end

endmodule

// ===== filelist.f =====
rtl/tvs_pkg.sv
rtl/tvs_pool_ram.sv
rtl/tag_value_store_bump_pool_unit.sv
sim/tag_value_store_bump_pool_unit_tb.sv
